>>> hw/rtl/gdt_pkg.sv
// ----------------------------------------------------------------------------
// Graph traversal package
// Field widths, payload structs, command codes and the sequencer microcode
// shared by the traversal block, its RAM and its checker.
// ----------------------------------------------------------------------------
package gdt_pkg;

  localparam int DEFAULT_MAX_VERTICES = 32;

  localparam int MODE_W   = 2;
  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 6;
  localparam int VISIT_W  = 6;

  // Command modes.
  localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DFS    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BFS    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Event kinds.
  localparam logic KIND_DISCOVER = 1'b0;
  localparam logic KIND_RETIRE   = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [VERTEX_W-1:0] first_vertex;
    logic [VERTEX_W-1:0] second_vertex;
  } cmd_t;

  typedef struct packed {
    logic                event_kind;
    logic [VERTEX_W-1:0] event_vertex;
    logic [VISIT_W-1:0]  visit_number;
    logic                last_event;
  } evt_t;

  // Sequencer step addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_START  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RETIRE = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DONE   = 3'd6;

  // Datapath operations.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
  localparam logic [OP_W-1:0] OP_SCAN   = 3'd3;
  localparam logic [OP_W-1:0] OP_RETIRE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // Sequencing conditions.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_SEQ    = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] COND_GO     = 3'd2;
  localparam logic [COND_W-1:0] COND_SCAN   = 3'd3;
  localparam logic [COND_W-1:0] COND_MORE   = 3'd4;

  typedef struct packed {
    logic              emit;
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // The control program. A step with emit set waits until the event slot is free.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    unique case (step)
      STEP_IDLE:   cw = '{emit: 1'b0, op: OP_NONE,   cond: COND_GO,     target: STEP_START};
      STEP_START:  cw = '{emit: 1'b1, op: OP_START,  cond: COND_SEQ,    target: STEP_IDLE};
      STEP_FETCH:  cw = '{emit: 1'b0, op: OP_NONE,   cond: COND_SEQ,    target: STEP_IDLE};
      STEP_LOAD:   cw = '{emit: 1'b0, op: OP_LOAD,   cond: COND_SEQ,    target: STEP_IDLE};
      STEP_SCAN:   cw = '{emit: 1'b1, op: OP_SCAN,   cond: COND_SCAN,   target: STEP_FETCH};
      STEP_RETIRE: cw = '{emit: 1'b1, op: OP_RETIRE, cond: COND_MORE,   target: STEP_FETCH};
      STEP_DONE:   cw = '{emit: 1'b0, op: OP_CLEAR,  cond: COND_ALWAYS, target: STEP_IDLE};
      default:     cw = '{emit: 1'b0, op: OP_NONE,   cond: COND_ALWAYS, target: STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> hw/rtl/gdt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdt_ram #(
  parameter int WIDTH = $clog2(gdt_pkg::DEFAULT_MAX_VERTICES),
  parameter int DEPTH = gdt_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/graph_dfs_bfs_traversal.sv
// ----------------------------------------------------------------------------
// Graph depth-first and breadth-first traversal
// Adjacency bit matrix with a microcoded walk sequencer and an event register.
// ----------------------------------------------------------------------------
// The block holds a directed adjacency matrix of up to MAX_VERTICES vertices,
// cleared by reset. A command with mode edge sets one bit of the matrix;
// vertices are numbered from 1 and an edge that names
// vertex 0 or a vertex above MAX_VERTICES is dropped. A command with mode
// depth-first or breadth-first walks the graph from the given vertex, using
// only vertices numbered up to the vertex_count register (clamped to
// MAX_VERTICES),
// and produces one discover event per vertex reached, carrying its visit
// number, and one retire event per vertex leaving the stack or queue; the
// final event of a walk has last_event set. A start vertex of 0 or above the
// count, and mode 3, produce no events. No command is taken while a walk is
// running. A walk runs the fetch, load and scan steps of the sequencer
// around the registered read of the pending-vertex RAM. Each walk step that
// produces an event waits while the previous event has not been transferred.
// vertex_count may be written only while no walk is running.
module graph_dfs_bfs_traversal #(
  parameter int MAX_VERTICES = gdt_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [gdt_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  gdt_pkg::cmd_t                cmd,
  output logic                         evt_valid,
  input  logic                         evt_stall,
  output gdt_pkg::evt_t                evt
);

  import gdt_pkg::*;

  // Vertex indexes are zero-based inside the block.
  localparam int IDX_W = $clog2(MAX_VERTICES);
  // Stack and queue pointers and the visit counter can reach MAX_VERTICES.
  localparam int PTR_W = $clog2(MAX_VERTICES + 1);

  logic [COUNT_W-1:0]      vertex_count;
  logic [MAX_VERTICES-1:0] adj [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] row;
  logic [IDX_W-1:0]        cur;
  logic                    dfs;
  logic [PTR_W-1:0]        front;
  logic [PTR_W-1:0]        back;
  logic [PTR_W-1:0]        visits;
  logic [STEP_W-1:0]       step;
  logic [STEP_W-1:0]       step_next;
  ctrl_t                   cw;

  logic [COUNT_W-1:0]      cnt_eff;
  logic [MAX_VERTICES-1:0] in_use;
  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] lowbit;
  logic [IDX_W-1:0]        pick;
  logic                    found;
  logic                    last;

  logic                    cmd_take;
  logic                    a_ok;
  logic                    b_ok;
  logic                    edge_ok;
  logic                    walk_go;
  logic [IDX_W-1:0]        a_idx;
  logic [IDX_W-1:0]        b_idx;

  logic                    emit_ok;
  logic                    run;
  logic                    emit_now;
  logic [PTR_W-1:0]        top_ptr;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [IDX_W-1:0]        ram_rdata;

  assign cw = ucode(step);

  // Commands are taken only while the sequencer sits in its idle step.
  assign cmd_stall = (step != STEP_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;

  assign cnt_eff = (vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                            : vertex_count;

  assign a_ok  = (cmd.first_vertex != '0) &&
                 (cmd.first_vertex <= VERTEX_W'(MAX_VERTICES));
  assign b_ok  = (cmd.second_vertex != '0) &&
                 (cmd.second_vertex <= VERTEX_W'(MAX_VERTICES));
  assign a_idx = IDX_W'(cmd.first_vertex - VERTEX_W'(1));
  assign b_idx = IDX_W'(cmd.second_vertex - VERTEX_W'(1));

  assign edge_ok = cmd_take && (cmd.mode == MODE_EDGE) && a_ok && b_ok;
  assign walk_go = cmd_take && ((cmd.mode == MODE_DFS) || (cmd.mode == MODE_BFS)) &&
                   (cmd.first_vertex != '0) && (cmd.first_vertex <= cnt_eff);

  // Neighbor scan: the row of the current vertex, minus visited vertices and
  // vertices beyond the count. The lowest remaining bit is the next discovery.
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      in_use[i] = (COUNT_W'(i) < cnt_eff);
    end
  end

  assign cand   = row & ~visited & in_use;
  assign found  = |cand;
  assign lowbit = cand & (~cand + MAX_VERTICES'(1));

  always_comb begin
    pick = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (lowbit[i]) begin
        pick = pick | IDX_W'(i);
      end
    end
  end

  // A retire ends the walk when the stack or queue becomes empty.
  assign last = dfs ? (back == PTR_W'(1)) : (PTR_W'(front + PTR_W'(1)) == back);

  // A step that produces an event runs only when the event slot is free.
  assign emit_ok  = !evt_valid || !evt_stall;
  assign run      = !cw.emit || emit_ok;
  assign emit_now = run && ((cw.op == OP_START) || (cw.op == OP_RETIRE) ||
                            ((cw.op == OP_SCAN) && found));

  always_comb begin
    step_next = step;
    if (run) begin
      unique case (cw.cond)
        COND_SEQ:    step_next = step + STEP_W'(1);
        COND_ALWAYS: step_next = cw.target;
        COND_GO:     step_next = walk_go ? cw.target : step;
        COND_SCAN:   step_next = found ? (dfs ? cw.target : step) : step + STEP_W'(1);
        COND_MORE:   step_next = last ? step + STEP_W'(1) : cw.target;
        default:     step_next = STEP_IDLE;
      endcase
    end
  end

  // The pending-vertex RAM serves as the stack for depth-first walks and as
  // the queue for breadth-first walks. The read address is presented in the
  // fetch step and the data is picked up in the load step.
  assign top_ptr   = back - PTR_W'(1);
  assign ram_raddr = dfs ? top_ptr[IDX_W-1:0] : front[IDX_W-1:0];
  assign ram_we    = run && ((cw.op == OP_START) || ((cw.op == OP_SCAN) && found));
  assign ram_waddr = (cw.op == OP_START) ? '0 : back[IDX_W-1:0];
  assign ram_wdata = (cw.op == OP_START) ? cur : pick;

  gdt_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_VERTICES)
  ) u_pending (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state, visit marks and the adjacency matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_IDLE;
      vertex_count <= '0;
      visited      <= '0;
      front        <= '0;
      back         <= '0;
      visits       <= '0;
      evt_valid    <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
    end else begin
      step <= step_next;
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      if (edge_ok) begin
        adj[a_idx][b_idx] <= 1'b1;
      end
      if (emit_now) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
      if (run) begin
        case (cw.op)
          OP_START: begin
            visited <= MAX_VERTICES'(1) << cur;
            visits  <= PTR_W'(1);
            back    <= PTR_W'(1);
            front   <= '0;
          end
          OP_SCAN: begin
            if (found) begin
              visited <= visited | lowbit;
              visits  <= visits + PTR_W'(1);
              back    <= back + PTR_W'(1);
            end
          end
          OP_RETIRE: begin
            if (dfs) begin
              back <= back - PTR_W'(1);
            end else begin
              front <= front + PTR_W'(1);
            end
          end
          OP_CLEAR: begin
            visited <= '0;
            front   <= '0;
            back    <= '0;
            visits  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Walk payload: current vertex, its adjacency row and the event register.
  always_ff @(posedge clk) begin
    if (walk_go) begin
      cur <= a_idx;
      dfs <= (cmd.mode == MODE_DFS);
    end
    if (run && (cw.op == OP_LOAD)) begin
      cur <= ram_rdata;
      row <= adj[ram_rdata];
    end
    if (emit_now) begin
      case (cw.op)
        OP_START: begin
          evt <= '{event_kind:   KIND_DISCOVER,
                   event_vertex: VERTEX_W'(cur) + VERTEX_W'(1),
                   visit_number: VISIT_W'(1),
                   last_event:   1'b0};
        end
        OP_SCAN: begin
          evt <= '{event_kind:   KIND_DISCOVER,
                   event_vertex: VERTEX_W'(pick) + VERTEX_W'(1),
                   visit_number: VISIT_W'(visits) + VISIT_W'(1),
                   last_event:   1'b0};
        end
        default: begin
          evt <= '{event_kind:   KIND_RETIRE,
                   event_vertex: VERTEX_W'(cur) + VERTEX_W'(1),
                   visit_number: '0,
                   last_event:   last};
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/gdt_checker.sv
// ----------------------------------------------------------------------------
// Graph traversal checker
// Port-level assertions on the event stream, bound to the traversal block.
// ----------------------------------------------------------------------------
module gdt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_stall,
  input logic                        evt_valid,
  input logic                        evt_stall,
  input gdt_pkg::evt_t               evt
);

  import gdt_pkg::*;

  // A stalled event stays offered and unchanged.
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("stalled event changed or dropped");

  // Until the final event is transferred the walk holds off new commands.
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_stall && !evt.last_event |-> cmd_stall)
    else $error("command accepted in the middle of a walk");

  // Retire events carry no visit number.
  a_retire_num: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt.event_kind == KIND_RETIRE) |-> (evt.visit_number == '0))
    else $error("retire event with a visit number");

  // A discovery always has a visit number and is never the final event.
  a_discover: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt.event_kind == KIND_DISCOVER) |->
      (evt.visit_number != '0) && !evt.last_event)
    else $error("malformed discover event");

endmodule

bind graph_dfs_bfs_traversal gdt_checker u_gdt_checker (.*);

>>> bench/tb_graph_dfs_bfs_traversal.sv
// ----------------------------------------------------------------------------
// Testbench for the graph depth-first and breadth-first traversal block
// Edge and walk commands go in with random gaps and events come out under
// random back-pressure. A behavioral model of the adjacency matrix and both
// walks predicts every event, and each transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_graph_dfs_bfs_traversal;
  import gdt_pkg::*;

  localparam int VERTICES      = DEFAULT_MAX_VERTICES;
  // Generous bound: every item a full walk of 64 events, each stalled to
  // the limit, taken several times over.
  localparam int CYCLE_LIMIT   = 3000000;
  // Quiet cycles after the last expected event before the block is
  // considered idle (an edge command or a finishing walk may still be busy).
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 32;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [COUNT_W-1:0]  cfg_data = '0;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  cmd_t                cmd = '0;
  logic                evt_valid;
  logic                evt_stall = 1'b0;
  evt_t                evt;

  graph_dfs_bfs_traversal uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: the adjacency matrix (row = source, bit = target, both
  // 0-based) and the vertex count after clamping to the matrix size.
  logic [VERTICES-1:0] adj_row [VERTICES];
  int unsigned         active_vertices = 0;

  // Events still owed by the block, oldest first. The newest predicted event
  // is held back one step so that the final one of a walk can be flagged.
  evt_t                expected_events [$];
  evt_t                held_event;
  bit                  held_valid = 1'b0;

  bit                  idle_on = 1'b1;
  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         stall_left = 0;

  initial begin
    foreach (adj_row[i]) adj_row[i] = '0;
  end

  function automatic void note_event(logic kind, int unsigned vtx, int unsigned num);
    if (held_valid) expected_events.push_back(held_event);
    held_event.event_kind   = kind;
    held_event.event_vertex = VERTEX_W'(vtx + 1);
    held_event.visit_number = VISIT_W'(num);
    held_event.last_event   = 1'b0;
    held_valid = 1'b1;
  endfunction

  // Runs one complete walk from a 0-based start vertex and queues its events.
  // The depth-first walk always extends the top of the stack with its
  // lowest-numbered fresh neighbour; the breadth-first walk discovers all
  // fresh neighbours of the queue head in ascending order before retiring it.
  function automatic void predict_walk(logic [MODE_W-1:0] m, int unsigned start);
    logic [VERTICES-1:0] seen;
    int unsigned         pending [VERTICES];
    int unsigned         head;
    int unsigned         tail;
    int unsigned         visits;
    int unsigned         produced;
    int unsigned         cur;
    bit                  found;
    seen = '0;
    seen[start] = 1'b1;
    visits = 1;
    produced = 1;
    note_event(KIND_DISCOVER, start, visits);
    pending[0] = start;
    head = 0;
    tail = 1;
    if (m == MODE_DFS) begin
      while (tail != 0 && produced < 2 * VERTICES) begin
        cur = pending[tail - 1];
        found = 1'b0;
        for (int unsigned nb = 0; nb < active_vertices && !found; nb++) begin
          if (adj_row[cur][nb] && !seen[nb]) begin
            seen[nb] = 1'b1;
            visits++;
            produced++;
            note_event(KIND_DISCOVER, nb, visits);
            pending[tail] = nb;
            tail++;
            found = 1'b1;
          end
        end
        if (!found) begin
          tail--;
          produced++;
          note_event(KIND_RETIRE, cur, 0);
        end
      end
    end else begin
      while (head != tail && produced < 2 * VERTICES) begin
        cur = pending[head];
        for (int unsigned nb = 0; nb < active_vertices; nb++) begin
          if (adj_row[cur][nb] && !seen[nb]) begin
            seen[nb] = 1'b1;
            visits++;
            produced++;
            note_event(KIND_DISCOVER, nb, visits);
            pending[tail] = nb;
            tail++;
          end
        end
        head++;
        produced++;
        note_event(KIND_RETIRE, cur, 0);
      end
    end
    held_event.last_event = 1'b1;
    expected_events.push_back(held_event);
    held_valid = 1'b0;
  endfunction

  // Updates the model for one accepted command.
  function automatic void predict_command(cmd_t c);
    int unsigned a;
    int unsigned b;
    a = c.first_vertex;
    b = c.second_vertex;
    case (c.mode)
      MODE_EDGE: begin
        if (a >= 1 && a <= VERTICES && b >= 1 && b <= VERTICES) adj_row[a - 1][b - 1] = 1'b1;
      end
      MODE_DFS, MODE_BFS: begin
        if (a >= 1 && a <= active_vertices) predict_walk(c.mode, a - 1);
      end
      default: begin
      end
    endcase
  endfunction

  // Presents one command after a random gap and waits for its transfer.
  // Valid is only lowered when a gap follows, so back-to-back commands keep
  // it high across the edge.
  task automatic send_command(logic [MODE_W-1:0] m, int unsigned a, int unsigned b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= '{mode: m, first_vertex: VERTEX_W'(a), second_vertex: VERTEX_W'(b)};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_command('{mode: m, first_vertex: VERTEX_W'(a), second_vertex: VERTEX_W'(b)});
  endtask

  // Lets every owed event arrive, then a few quiet cycles.
  task automatic drain_events();
    cmd_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(int unsigned count);
    drain_events();
    cfg_write <= 1'b1;
    cfg_data <= COUNT_W'(count);
    @(posedge clk);
    cfg_write <= 1'b0;
    active_vertices = (count > VERTICES) ? VERTICES : count;
  endtask

  // With no vertices in use nothing walks; meanwhile build a small graph,
  // including the corner vertices, a self loop, and edges that are dropped.
  task automatic test_empty_graph();
    write_vertex_count(0);
    send_command(MODE_DFS, 1, 1);
    send_command(MODE_BFS, 1, 1);
    send_command(MODE_EDGE, 1, 2);
    send_command(MODE_EDGE, 2, 3);
    send_command(MODE_EDGE, 3, 1);
    send_command(MODE_EDGE, 1, 32);
    send_command(MODE_EDGE, 32, 1);
    send_command(MODE_EDGE, 1, 1);
    send_command(MODE_EDGE, 0, 5);
    send_command(MODE_EDGE, 5, 0);
    send_command(MODE_EDGE, 33, 4);
    send_command(MODE_EDGE, 63, 63);
    send_command(MODE_UNUSED, 63, 63);
  endtask

  // Full graph size: both walks, a start at the top vertex, and starts that
  // fall outside the range.
  task automatic test_full_count();
    write_vertex_count(VERTICES);
    send_command(MODE_DFS, 1, 0);
    send_command(MODE_BFS, 1, 63);
    send_command(MODE_BFS, 32, 0);
    send_command(MODE_DFS, 0, 0);
    send_command(MODE_BFS, 33, 0);
  endtask

  // A count above the matrix size behaves as the matrix size.
  task automatic test_count_clamp();
    write_vertex_count(63);
    send_command(MODE_DFS, 32, 0);
    send_command(MODE_BFS, 2, 0);
  endtask

  // With three vertices the edge to vertex 32 is kept but not followed, and
  // a start just above the count does nothing.
  task automatic test_hidden_neighbors();
    write_vertex_count(3);
    send_command(MODE_DFS, 1, 0);
    send_command(MODE_BFS, 3, 0);
    send_command(MODE_DFS, 4, 0);
  endtask

  // A single vertex with a self loop discovers and retires only itself.
  task automatic test_single_vertex();
    write_vertex_count(1);
    send_command(MODE_DFS, 1, 0);
    send_command(MODE_BFS, 1, 0);
  endtask

  // Random phases, each with its own vertex count. Most commands are edges
  // between vertices in use and walks from a valid start; the rest are
  // commands with random bits, which do not count toward the phase quota.
  task automatic test_random_traffic();
    int unsigned count;
    int unsigned lim;
    int unsigned done;
    int unsigned pick;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 5)
        0: count = VERTICES;
        1: count = $urandom_range(1, VERTICES);
        2: count = $urandom_range(VERTICES + 1, 63);
        3: count = $urandom_range(2, 6);
        default: count = $urandom_range(7, VERTICES - 1);
      endcase
      write_vertex_count(count);
      lim = active_vertices;
      // Every third phase runs without gaps or stalls.
      idle_on = (phase % 3) != 2;
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_command(MODE_EDGE, $urandom_range(1, lim), $urandom_range(1, lim));
          done++;
        end else if (pick < 88) begin
          send_command(($urandom_range(0, 1) != 0) ? MODE_DFS : MODE_BFS,
                       $urandom_range(1, lim), $urandom_range(0, 63));
          done++;
        end else begin
          send_command(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                       $urandom_range(0, 63));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_graph();
    test_full_count();
    test_count_clamp();
    test_hidden_neighbors();
    test_single_vertex();
    test_random_traffic();
    drain_events();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Event side: check each transfer against the oldest owed event, then draw
  // how long to hold off the next one.
  always @(posedge clk) begin
    evt_t        want;
    int unsigned hold;
    if (rst) begin
      evt_stall <= 1'b0;
      stall_left <= 0;
    end else if (evt_valid && !evt_stall) begin
      if (expected_events.size() == 0) begin
        $error("event for vertex %0d arrived with no event expected", evt.event_vertex);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        if (evt.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind, evt.event_kind);
          fail_count++;
        end
        if (evt.event_vertex !== want.event_vertex) begin
          $error("event_vertex: expected %0d, got %0d", want.event_vertex, evt.event_vertex);
          fail_count++;
        end
        if (evt.visit_number !== want.visit_number) begin
          $error("visit_number: expected %0d, got %0d", want.visit_number, evt.visit_number);
          fail_count++;
        end
        if (evt.last_event !== want.last_event) begin
          $error("last_event: expected %0d, got %0d", want.last_event, evt.last_event);
          fail_count++;
        end
      end
      hold = idle_on ? $urandom_range(0, 17) : 0;
      stall_left <= hold;
      evt_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      evt_stall <= (stall_left != 1);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
